/* src/hale_pkg.sv */
package hale_pkg;

    // Number of characters on one address line.
    localparam int DIGIT_COUNT = 3;

    localparam int FILL_W     = $clog2(DIGIT_COUNT + 1);
    localparam int SLOT_IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam int VALUE_W    = 4 * DIGIT_COUNT;
    localparam int ADDR_W     = 12;
    localparam int CMP_W      = (VALUE_W > ADDR_W) ? VALUE_W : ADDR_W;
    localparam int CHAR_W     = 8;

    // Most items one character can produce.
    localparam int MAX_RESULTS = 3;
    localparam int RES_CNT_W   = 2;

    localparam logic [ADDR_W-1:0] LIMIT_RESET = 12'd1023;

    localparam logic [CHAR_W-1:0] CH_DELETE     = 8'h7F;
    localparam logic [CHAR_W-1:0] CH_ENTER      = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_NEWLINE    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE  = 8'h08;
    localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_LO   = 8'h30;  // '0'
    localparam logic [CHAR_W-1:0] CH_PRINT_HI   = 8'h7A;  // 'z'
    localparam logic [CHAR_W-1:0] CH_DIGIT_LO   = 8'h30;  // '0'
    localparam logic [CHAR_W-1:0] CH_DIGIT_HI   = 8'h39;  // '9'
    localparam logic [CHAR_W-1:0] CH_HEX_LO     = 8'h41;  // 'A'
    localparam logic [CHAR_W-1:0] CH_HEX_HI     = 8'h46;  // 'F'

    typedef enum logic [1:0] {
        KIND_ECHO      = 2'd0,
        KIND_ADDR_OK   = 2'd1,
        KIND_FMT_ERR   = 2'd2,
        KIND_RANGE_ERR = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [CHAR_W-1:0]  echo;
        logic [ADDR_W-1:0]  addr;
        logic               last;
    } t_result;

    // Results of one character, slot 0 goes out first.
    typedef struct packed {
        logic [RES_CNT_W-1:0]               count;
        t_result [MAX_RESULTS-1:0]          res;
    } t_line_out;

    localparam logic REG_ADDRESS_LIMIT = 1'b0;

endpackage

/* src/hale_line.sv */
module hale_line
    import hale_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [CHAR_W-1:0] i_char,
    input  logic [ADDR_W-1:0] i_limit,
    output t_line_out         o_line
);

    logic [CHAR_W-1:0] r_slots [DIGIT_COUNT];
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;

    logic [DIGIT_COUNT-1:0] slot_ok;
    logic [3:0]             nib [DIGIT_COUNT];
    logic [VALUE_W-1:0]     value;
    logic                   line_ok;
    logic                   is_enter;
    logic                   is_del;
    logic                   is_print;
    logic                   do_store;
    t_kind                  verdict;

    // Per-slot hex decode, uppercase only.
    always_comb begin
        for (int i = 0; i < DIGIT_COUNT; i++) begin
            if (r_slots[i] >= CH_DIGIT_LO && r_slots[i] <= CH_DIGIT_HI) begin
                slot_ok[i] = 1'b1;
                nib[i]     = 4'(r_slots[i] - CH_DIGIT_LO);
            end else if (r_slots[i] >= CH_HEX_LO && r_slots[i] <= CH_HEX_HI) begin
                slot_ok[i] = 1'b1;
                nib[i]     = 4'(r_slots[i] - CH_HEX_LO + 8'd10);
            end else begin
                slot_ok[i] = 1'b0;
                nib[i]     = 4'd0;
            end
            value[4*(DIGIT_COUNT-1-i) +: 4] = nib[i];
        end
    end

    assign line_ok  = (r_fill == FILL_W'(DIGIT_COUNT)) && (&slot_ok);
    assign is_enter = (i_char == CH_ENTER);
    assign is_del   = (i_char == CH_DELETE);
    assign is_print = (i_char >= CH_PRINT_LO) && (i_char <= CH_PRINT_HI);
    assign do_store = is_print && (r_fill < FILL_W'(DIGIT_COUNT));

    always_comb begin
        if (!line_ok) begin
            verdict = KIND_FMT_ERR;
        end else if (CMP_W'(value) > CMP_W'(i_limit)) begin
            verdict = KIND_RANGE_ERR;
        end else begin
            verdict = KIND_ADDR_OK;
        end
    end

    always_comb begin
        o_line = '0;
        n_fill = r_fill;
        for (int k = 0; k < MAX_RESULTS; k++) begin
            o_line.res[k].kind = KIND_ECHO;
        end
        if (is_enter) begin
            o_line.count       = RES_CNT_W'(3);
            o_line.res[0].echo = CH_NEWLINE;
            o_line.res[1].echo = CH_ENTER;
            o_line.res[2].kind = verdict;
            o_line.res[2].addr = (verdict == KIND_FMT_ERR) ? '0 : ADDR_W'(value);
            o_line.res[2].last = 1'b1;
            n_fill             = '0;
        end else if (is_del) begin
            if (r_fill != '0) begin
                o_line.count       = RES_CNT_W'(3);
                o_line.res[0].echo = CH_BACKSPACE;
                o_line.res[1].echo = CH_SPACE;
                o_line.res[2].echo = CH_BACKSPACE;
                o_line.res[2].last = 1'b1;
                n_fill             = r_fill - FILL_W'(1);
            end
        end else if (do_store) begin
            o_line.count       = RES_CNT_W'(1);
            o_line.res[0].echo = i_char;
            o_line.res[0].last = 1'b1;
            n_fill             = r_fill + FILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_fire) begin
            r_fill <= n_fill;
        end
    end

    // Slots past the fill count are never looked at, so no clearing is needed.
    always_ff @(posedge i_clk) begin
        if (i_fire && !is_enter && !is_del && do_store) begin
            r_slots[r_fill[SLOT_IDX_W-1:0]] <= i_char;
        end
    end

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(DIGIT_COUNT))
        else $error("fill count beyond line length");

    a_enter_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && is_enter) |=> (r_fill == '0))
        else $error("line not cleared after carriage return");

endmodule

/* src/hex_address_line_entry_top.sv */
// Hex address line entry. Feed received characters in on the input channel; each
// one is registered, then edited into a three-character line buffer, and the
// items it causes (echo bytes, then for a carriage return the verdict: address
// accepted, format error or range error) queue up for the output channel, with
// o_last_of_run marking the final item of each character. A character that
// causes nothing (bytes below '0' other than carriage return, bytes above 'z'
// other than delete, printable bytes on a full line, delete on an empty line)
// is absorbed. Characters giving zero or one item are taken at one per cycle
// while the output is not stalled; delete and carriage return give three items
// each, and the result port gives out at most one item per cycle. Results pass
// the input register, then the result queue. The limit register (byte address
// 0, reset 1023) may only be written while no character is in flight.
module hex_address_line_entry_top
    import hale_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [CHAR_W-1:0] i_rx_char,
    // output channel
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_result_kind,
    output logic [CHAR_W-1:0] o_echo_byte,
    output logic [ADDR_W-1:0] o_entered_address,
    output logic              o_last_of_run,
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Input register
    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;

    // Result queue
    t_result           r_q [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    logic [ADDR_W-1:0] r_limit;

    t_line_out            line;
    logic                 move;
    logic                 accept;
    logic                 pop;
    logic [RES_CNT_W-1:0] push_cnt;
    logic                 reg_wr;
    t_result              head;

    // Room for a full run of results is checked against the registered count,
    // so stall never waits on the downstream side combinationally.
    assign move     = r_in_valid && (r_count <= CNT_W'(QUEUE_DEPTH - MAX_RESULTS));
    assign o_stall  = r_in_valid && !move;
    assign accept   = i_valid && !o_stall;
    assign push_cnt = move ? line.count : '0;
    assign pop      = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_char <= i_rx_char;
        end
    end

    hale_line u_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (move),
        .i_char  (r_in_char),
        .i_limit (r_limit),
        .o_line  (line)
    );

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (RES_CNT_W'(k) < push_cnt) begin
                r_q[r_wr_ptr + PTR_W'(k)] <= line.res[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(push_cnt);
            r_rd_ptr <= r_rd_ptr + PTR_W'(pop);
            r_count  <= r_count + CNT_W'(push_cnt) - CNT_W'(pop);
        end
    end

    assign head              = r_q[r_rd_ptr];
    assign o_valid           = (r_count != '0);
    assign o_result_kind     = head.kind;
    assign o_echo_byte       = head.echo;
    assign o_entered_address = head.addr;
    assign o_last_of_run     = head.last;

    // Register port: single register, no wait states.
    assign pready = 1'b1;
    assign reg_wr = psel && penable && pwrite && (paddr[2] == REG_ADDRESS_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (reg_wr) begin
            r_limit <= pwdata[ADDR_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_ADDRESS_LIMIT) ? 32'(r_limit) : '0;

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("result queue overfilled");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_count == $past(r_count) + CNT_W'($past(push_cnt)) - CNT_W'($past(pop)))
        else $error("queue count out of step with pushes and pops");

    a_verdict_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (head.kind != KIND_ECHO)) |-> o_last_of_run)
        else $error("verdict item not marked last");

    a_move_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && !accept) |=> !r_in_valid)
        else $error("input register not released after move");

endmodule
